FILE: hdl/bfa_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfa_pkg
// Shared types, codes and sizes for the bitmap frame allocator.
// ---------------------------------------------------------------------------
package bfa_pkg;

  // default sizing
  localparam int MAX_FRAMES_DEF = 4096;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int WORD_BITS_DEF  = 64;

  // fixed field widths
  localparam int REQ_W    = 2;
  localparam int IDX_W    = 12;
  localparam int BYTE_W   = 48;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 24;
  localparam int LIMIT_W  = 13;

  // frame positions inside the sequencer: limit width plus one bit of overrun
  localparam int FRAME_W = LIMIT_W + 1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREE_ALRD = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_LEN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_FRAME  = 3'd4;

  // word unit operations
  localparam logic [1:0] OP_FIND = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_CLR  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [IDX_W-1:0]  frame_index;
    logic [BYTE_W-1:0] range_base;
    logic [BYTE_W-1:0] range_length;
    logic              mark_used;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_address;
    logic [LIMIT_W-1:0]  used_count;
  } rsp_t;

  // control from sequencer to word unit
  typedef struct packed {
    logic [1:0]         op;
    logic [FRAME_W-1:0] wbase;
    logic [FRAME_W-1:0] lo;
    logic [FRAME_W-1:0] hi;
  } word_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/bfa_bitmap_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfa_bitmap_ram
// Bitmap storage: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module bfa_bitmap_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bfa_word_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfa_word_unit
// Shared per-word unit: range mask, first-free search, set/clear, popcount of changed bits.
// ---------------------------------------------------------------------------
module bfa_word_unit #(
  parameter int WORD_BITS = 64,
  parameter int BIT_W     = 6,
  parameter int POP_W     = 7
) (
  input  wire logic                  [WORD_BITS-1:0] data,
  input  wire bfa_pkg::word_ctl_t                    ctl,
  output logic                       [WORD_BITS-1:0] new_word,
  output logic                                       hit,
  output logic                       [BIT_W-1:0]     hit_bit,
  output logic                       [POP_W-1:0]     pop
);

  logic [bfa_pkg::FRAME_W-1:0] lo_rel;
  logic [bfa_pkg::FRAME_W-1:0] hi_rel;
  logic [WORD_BITS-1:0]        mask;
  logic [WORD_BITS-1:0]        free_bits;
  logic [WORD_BITS-1:0]        pick;
  logic [WORD_BITS-1:0]        diff;

  // range bounds relative to this word's first frame
  assign lo_rel = (ctl.lo > ctl.wbase) ? ctl.lo - ctl.wbase : '0;
  assign hi_rel = (ctl.hi > ctl.wbase) ? ctl.hi - ctl.wbase : '0;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (bfa_pkg::FRAME_W'(b) >= lo_rel) && (bfa_pkg::FRAME_W'(b) < hi_rel);
    end
  end

  assign free_bits = ~data & mask;

  // lowest free bit
  always_comb begin
    hit_bit = '0;
    pick    = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit_bit = BIT_W'(b);
        pick    = WORD_BITS'(1) << b;
      end
    end
  end

  assign hit = |free_bits;

  always_comb begin
    case (ctl.op)
      bfa_pkg::OP_FIND: new_word = data | pick;
      bfa_pkg::OP_SET:  new_word = data | mask;
      bfa_pkg::OP_CLR:  new_word = data & ~mask;
      default:          new_word = data;
    endcase
  end

  assign diff = new_word ^ data;

  always_comb begin
    pop = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      pop = pop + POP_W'(diff[b]);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bitmap_frame_allocator_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_frame_allocator_unit
// First-fit page frame allocator over a used/free bitmap.
// ---------------------------------------------------------------------------
// One bit per frame is kept in a single-port-write, registered-read RAM of
// NWORDS = ceil(MAX_FRAMES / WORD_BITS) words, and a sequencer walks it a
// word at a time through one shared word unit. After reset the block runs a
// clearing pass over all NWORDS words (64 at the defaults) with req_ready
// low; cfg writes are taken throughout. Per request: allocate examines words
// in order until a free frame below the limit turns up or none is left;
// free skips the words below frame_index / WORD_BITS, then reads and
// modifies that word, or answers without a walk when out of range; mark
// does range setup, skips the words before the first frame and touches each
// word in range, or stops after setup when the range starts past the limit.
// Zero length and unknown requests answer without a walk. The word walk does
// one RAM read and one read-modify-write per word examined. The result sits
// in an output register, so the next word is accepted while a result waits;
// a finished request stalls only if the previous result has still not been
// taken. used_count is the count after the request. frame_limit values above
// MAX_FRAMES act as MAX_FRAMES; bits above a lowered limit keep counting but
// are unreachable.
// ---------------------------------------------------------------------------
module bitmap_frame_allocator_unit #(
  parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_SHIFT = bfa_pkg::PAGE_SHIFT_DEF,
  parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_ready,
  input  wire bfa_pkg::req_t                  req,
  output logic                                rsp_valid,
  input  wire logic                           rsp_ready,
  output bfa_pkg::rsp_t                       rsp,
  input  wire logic                           cfg_we,
  input  wire logic [bfa_pkg::LIMIT_W-1:0]    cfg_wdata
);

  localparam int NWORDS    = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int POP_W     = $clog2(WORD_BITS + 1);
  localparam int FW        = bfa_pkg::FRAME_W;
  localparam int LW        = bfa_pkg::LIMIT_W;
  localparam int BW        = bfa_pkg::BYTE_W;
  localparam int SUM_W     = BW + 1;
  localparam int AFULL_W   = FW + PAGE_SHIFT;
  localparam int AEXT_W    = (AFULL_W > bfa_pkg::ADDR_W) ? AFULL_W : bfa_pkg::ADDR_W;
  localparam int LIM_CAP_I = (MAX_FRAMES > 8191) ? 8191 : MAX_FRAMES;
  localparam logic [LW-1:0] LIM_CAP = LIM_CAP_I[LW-1:0];
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NWORDS - 1);
  localparam logic [FW:0]     WSTEP     = (FW + 1)'(WORD_BITS);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_PREP2 = 3'd3;
  localparam logic [2:0] S_SEEK  = 3'd4;
  localparam logic [2:0] S_MOD   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state;
  logic [LW-1:0] frame_limit;
  logic [LW-1:0] lim;
  logic [LW-1:0] used;

  // request context
  logic [bfa_pkg::REQ_W-1:0]    rtype;
  logic [1:0]                   op;
  logic [BW-1:0]                base;
  logic [BW-1:0]                len;
  logic [SUM_W-1:0]             end_sum;
  logic                         first_gt;
  logic [FW-1:0]                first;
  logic [FW-1:0]                last;
  logic [bfa_pkg::STATUS_W-1:0] status_r;
  logic [bfa_pkg::ADDR_W-1:0]   addr_r;

  // word walk
  logic [WA_W-1:0] w;
  logic [FW-1:0]   wbase;
  logic            seek_end;
  logic            seek_skip;

  // ram and word unit
  logic                 ram_we;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  bfa_pkg::word_ctl_t   ctl;
  logic [WORD_BITS-1:0] new_word;
  logic                 hit;
  logic [BIT_W-1:0]     hit_bit;
  logic [POP_W-1:0]     pop;

  // mark range setup
  logic [BW-1:0]    first_full;
  logic [SUM_W-1:0] last_full;
  logic [FW-1:0]    hit_frame;
  logic [AEXT_W-1:0] addr_full;

  assign lim = (frame_limit > LIM_CAP) ? LIM_CAP : frame_limit;

  assign req_ready = (state == S_IDLE);

  // word starts at or past the range end, or word lies wholly below range
  assign seek_end  = (wbase >= last);
  assign seek_skip = ({1'b0, wbase} + WSTEP) <= {1'b0, first};

  assign first_full = req.range_base >> PAGE_SHIFT;
  assign last_full  = (end_sum >> PAGE_SHIFT) + SUM_W'(|end_sum[PAGE_SHIFT-1:0]);

  assign hit_frame = wbase + FW'(hit_bit);
  assign addr_full = AEXT_W'(hit_frame) << PAGE_SHIFT;

  assign ctl.op    = op;
  assign ctl.wbase = wbase;
  assign ctl.lo    = first;
  assign ctl.hi    = last;

  assign ram_we    = (state == S_CLEAR) || (state == S_MOD);
  assign ram_wdata = (state == S_CLEAR) ? '0 : new_word;
  assign ram_re    = (state == S_SEEK) && !seek_end && !seek_skip;

  bfa_bitmap_ram #(
    .DEPTH (NWORDS),
    .WIDTH (WORD_BITS),
    .AW    (WA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (w),
    .rdata (ram_rdata)
  );

  bfa_word_unit #(
    .WORD_BITS (WORD_BITS),
    .BIT_W     (BIT_W),
    .POP_W     (POP_W)
  ) u_word (
    .data     (ram_rdata),
    .ctl      (ctl),
    .new_word (new_word),
    .hit      (hit),
    .hit_bit  (hit_bit),
    .pop      (pop)
  );

  // config register, written any time
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= '0;
    end else if (cfg_we) begin
      frame_limit <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      w         <= '0;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // output register: load on a finished request, drop once taken
      if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          // zero one bitmap word per cycle
          w <= w + 1'b1;
          if (w == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            rtype    <= req.req_type;
            base     <= req.range_base;
            len      <= req.range_length;
            addr_r   <= '0;
            w        <= '0;
            wbase    <= '0;
            first_gt <= first_full > BW'(lim);
            case (req.req_type)
              bfa_pkg::REQ_ALLOC: begin
                op       <= bfa_pkg::OP_FIND;
                first    <= '0;
                last     <= FW'(lim);
                status_r <= bfa_pkg::ST_NO_FRAME;
                state    <= S_SEEK;
              end
              bfa_pkg::REQ_FREE: begin
                op    <= bfa_pkg::OP_CLR;
                first <= FW'(req.frame_index);
                last  <= FW'(req.frame_index) + 1'b1;
                if (LW'(req.frame_index) >= lim) begin
                  status_r <= bfa_pkg::ST_RANGE;
                  state    <= S_DONE;
                end else begin
                  status_r <= bfa_pkg::ST_OK;
                  state    <= S_SEEK;
                end
              end
              bfa_pkg::REQ_MARK: begin
                op <= req.mark_used ? bfa_pkg::OP_SET : bfa_pkg::OP_CLR;
                if (req.range_length == '0) begin
                  status_r <= bfa_pkg::ST_ZERO_LEN;
                  state    <= S_DONE;
                end else begin
                  status_r <= bfa_pkg::ST_OK;
                  state    <= S_PREP;
                end
              end
              default: begin
                status_r <= bfa_pkg::ST_OK;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_PREP: begin
          end_sum <= {1'b0, base} + {1'b0, len};
          state   <= S_PREP2;
        end
        S_PREP2: begin
          // first frame is known to be at or below the limit past this point
          first <= FW'(base >> PAGE_SHIFT);
          if (last_full > SUM_W'(lim)) begin
            last <= FW'(lim);
          end else begin
            last <= last_full[FW-1:0];
          end
          if (first_gt) begin
            status_r <= bfa_pkg::ST_NO_FRAME;
            state    <= S_DONE;
          end else begin
            state <= S_SEEK;
          end
        end
        S_SEEK: begin
          if (seek_end) begin
            state <= S_DONE;
          end else if (seek_skip) begin
            w     <= w + 1'b1;
            wbase <= wbase + FW'(WORD_BITS);
          end else begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (op == bfa_pkg::OP_CLR) begin
            used <= used - LW'(pop);
          end else begin
            used <= used + LW'(pop);
          end
          if (rtype == bfa_pkg::REQ_FREE) begin
            status_r <= (pop != '0) ? bfa_pkg::ST_OK : bfa_pkg::ST_FREE_ALRD;
            state    <= S_DONE;
          end else if ((op == bfa_pkg::OP_FIND) && hit) begin
            status_r <= bfa_pkg::ST_OK;
            addr_r   <= addr_full[bfa_pkg::ADDR_W-1:0];
            state    <= S_DONE;
          end else begin
            w     <= w + 1'b1;
            wbase <= wbase + FW'(WORD_BITS);
            state <= S_SEEK;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!rsp_valid || rsp_ready) begin
            rsp.status       <= status_r;
            rsp.page_address <= addr_r;
            rsp.used_count   <= used;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bfa_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfa_checker
// Port-level checks for the frame allocator, bound to the top level.
// ---------------------------------------------------------------------------
module bfa_checker #(
  parameter int PAGE_SHIFT = bfa_pkg::PAGE_SHIFT_DEF
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire bfa_pkg::rsp_t rsp
);

  // clearing pass keeps the request side closed right after reset
  a_clear_after_rst: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request accepted during bitmap clear");

  // sequential: nothing else is taken while a word is in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while busy");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("result dropped or changed while stalled");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != bfa_pkg::ST_OK)) |-> (rsp.page_address == '0))
    else $error("page address on a failed request");

  a_addr_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.page_address[PAGE_SHIFT-1:0] == '0))
    else $error("page address not page aligned");

endmodule

bind bitmap_frame_allocator_unit bfa_checker #(
  .PAGE_SHIFT (PAGE_SHIFT)
) u_bfa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire

FILE: verif/bfa_alloc_tracker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bfa_alloc_tracker
// Shadow bitmap, result prediction and comparison for the frame allocator.
// ---------------------------------------------------------------------------
// Watches the request, result and limit ports at each rising edge. Every
// accepted request word updates a private copy of the bitmap and queues the
// answer it should produce; every accepted result word is compared field by
// field with the oldest queued answer.
// ---------------------------------------------------------------------------
module bfa_alloc_tracker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  input  wire logic                          req_ready,
  input  wire bfa_pkg::req_t                 req,
  input  wire logic                          rsp_valid,
  input  wire logic                          rsp_ready,
  input  wire bfa_pkg::rsp_t                 rsp,
  input  wire logic                          cfg_we,
  input  wire logic [bfa_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  wire logic                          run_done,
  output int                                 mismatches,
  output int                                 rsp_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bfa_pkg::*;

  localparam int SHOWN_MAX = 40;
  localparam longint unsigned PAGE_MASK = (64'd1 << PAGE_SHIFT_DEF) - 1;

  logic [MAX_FRAMES_DEF-1:0] shadow_map;
  int unsigned               frames_in_use;
  logic [LIMIT_W-1:0]        frame_limit;
  rsp_t                      pending_answers[$];
  int                        rsp_seen;
  bit                        leftovers_checked;

  initial begin
    mismatches  = 0;
    rsp_pending = 0;
  end

  task automatic flag_mismatch(string msg);
    if (mismatches < SHOWN_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void put_frame(longint unsigned f, bit used);
    if (used && !shadow_map[f]) begin
      shadow_map[f] = 1'b1;
      frames_in_use++;
    end else if (!used && shadow_map[f]) begin
      shadow_map[f] = 1'b0;
      frames_in_use--;
    end
  endfunction

  // first fit allocate, single free, page-widened range mark
  task automatic apply_request(input req_t w, output rsp_t ans);
    longint unsigned lim, span_lo, span_hi, span_end, f;
    bit found;
    lim = (frame_limit > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : frame_limit;
    ans = '0;
    case (w.req_type)
      REQ_ALLOC: begin
        ans.status = ST_NO_FRAME;
        found = 1'b0;
        for (f = 0; f < lim && !found; f++) begin
          if (!shadow_map[f]) begin
            put_frame(f, 1'b1);
            ans.page_address = ADDR_W'(f << PAGE_SHIFT_DEF);
            ans.status = ST_OK;
            found = 1'b1;
          end
        end
      end
      REQ_FREE: begin
        if (w.frame_index >= lim) ans.status = ST_RANGE;
        else if (!shadow_map[w.frame_index]) ans.status = ST_FREE_ALRD;
        else put_frame(w.frame_index, 1'b0);
      end
      REQ_MARK: begin
        if (w.range_length == '0) begin
          ans.status = ST_ZERO_LEN;
        end else begin
          span_lo = w.range_base >> PAGE_SHIFT_DEF;
          span_end = longint'(w.range_base) + longint'(w.range_length);
          span_hi = (span_end >> PAGE_SHIFT_DEF) + ((span_end & PAGE_MASK) != 0);
          if (span_lo > lim) begin
            ans.status = ST_NO_FRAME;
          end else begin
            if (span_hi > lim) span_hi = lim;
            for (f = span_lo; f < span_hi; f++) put_frame(f, w.mark_used);
          end
        end
      end
      default: ;  // unknown code: ignored, ok status
    endcase
    ans.used_count = LIMIT_W'(frames_in_use);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      shadow_map        = '0;
      frames_in_use     = 0;
      frame_limit       = '0;
      rsp_seen          = 0;
      leftovers_checked = 1'b0;
      pending_answers.delete();
    end else begin
      if (cfg_we) frame_limit = cfg_wdata;
      if (rsp_valid && rsp_ready) begin
        if (pending_answers.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no request pending", rsp_seen));
        end else begin
          want = pending_answers.pop_front();
          if (rsp.status !== want.status)
            flag_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                    rsp_seen, rsp.status, want.status));
          if (rsp.page_address !== want.page_address)
            flag_mismatch($sformatf("result %0d page_address 0x%0h, predicted 0x%0h",
                                    rsp_seen, rsp.page_address, want.page_address));
          if (rsp.used_count !== want.used_count)
            flag_mismatch($sformatf("result %0d used_count %0d, predicted %0d",
                                    rsp_seen, rsp.used_count, want.used_count));
        end
        rsp_seen++;
      end
      if (req_valid && req_ready) begin
        apply_request(req, want);
        pending_answers.push_back(want);
      end
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (pending_answers.size() != 0)
          flag_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
      end
    end
    rsp_pending <= pending_answers.size();
  end

endmodule
`default_nettype wire

FILE: verif/bitmap_frame_allocator_unit_test.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bitmap_frame_allocator_unit_test
// Stimulus and verdict for the first-fit bitmap frame allocator.
// ---------------------------------------------------------------------------
// A directed opening walks the corner cases (limit of zero, allocate with
// nothing free, frees out of range and of free frames, zero-length marks,
// marks starting at and past the limit, clamped marks, a lowered limit, a
// limit above the frame count). Random phases follow, each under its own
// frame limit, with random gaps on both channels and one long result stall.
// Prediction and comparison live in bfa_alloc_tracker.
// ---------------------------------------------------------------------------
module bitmap_frame_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bfa_pkg::*;

  // request code the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  localparam int PHASE_WORDS    = 155;
  localparam int HOLD_AT_RESULT = 600;   // result count where the long stall starts
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 250;
  localparam int STALL_LIMIT    = 3000;  // cycles with no word moving on either side
  localparam int PAGE_BYTES     = 1 << PAGE_SHIFT_DEF;
  localparam logic [BYTE_W-1:0] BYTES_ALL = '1;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  req_t               req       = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  rsp_t               rsp;
  logic               cfg_we    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  logic               run_done  = 1'b0;

  int mismatches;
  int rsp_pending;
  int cur_limit    = 0;
  int send_calm    = 0;
  int recv_calm    = 0;
  int stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_frame_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bfa_alloc_tracker tracker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .run_done    (run_done),
    .mismatches  (mismatches),
    .rsp_pending (rsp_pending)
  );

  // Random gap before the next word. Now and then a burst of
  // back-to-back words so every phase also sees full rate.
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 40);
    return $urandom_range(0, 12);
  endfunction

  function automatic req_t make_word(logic [REQ_W-1:0] kind, int idx,
                                     logic [BYTE_W-1:0] base, logic [BYTE_W-1:0] len,
                                     bit used);
    req_t w;
    w.req_type     = kind;
    w.frame_index  = IDX_W'(idx);
    w.range_base   = base;
    w.range_length = len;
    w.mark_used    = used;
    return w;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_bytes();
    return BYTE_W'({$urandom(), $urandom()});
  endfunction

  // limits above the frame count behave as the frame count
  function automatic int frames_managed();
    return (cur_limit > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : cur_limit;
  endfunction

  // Mostly well-formed work: frees aimed at the low, allocated end of the
  // bitmap, marks starting inside the managed range or at its limit, with short lengths.
  // The rest is noise: full-width indexes, bases and lengths, unknown codes.
  function automatic req_t random_word(int lim);
    req_t w;
    int   pick;
    int   top_frame;
    int   page;
    w = make_word(REQ_ALLOC, $urandom_range(0, 4095), rand_bytes(), rand_bytes(),
                  $urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      w.req_type = REQ_ALLOC;
    end else if (pick < 65) begin
      w.req_type = REQ_FREE;
      if (lim > 0 && $urandom_range(0, 9) < 7) begin
        top_frame = lim - 1;
        if ($urandom_range(0, 1) && top_frame > 127) top_frame = 127;
        w.frame_index = IDX_W'($urandom_range(0, top_frame));
      end
    end else if (pick < 95) begin
      w.req_type = REQ_MARK;
      if ($urandom_range(0, 3) != 0) begin
        page = $urandom_range(0, lim);
        w.range_base = BYTE_W'(page) << PAGE_SHIFT_DEF;
        if ($urandom_range(0, 1)) w.range_base |= BYTE_W'($urandom_range(0, PAGE_BYTES - 1));
      end
      case ($urandom_range(0, 9))
        0:       w.range_length = '0;
        1, 2:    ;  // keep the full-width length
        3:       w.range_length = BYTE_W'($urandom_range(1, 64 * PAGE_BYTES));
        default: w.range_length = BYTE_W'($urandom_range(1, 4 * PAGE_BYTES));
      endcase
    end else begin
      w.req_type = REQ_UNKNOWN;
    end
    return w;
  endfunction

  // Offer one word and hold it until taken. valid is only dropped when a
  // gap is drawn, so back-to-back words keep it high.
  task automatic send_word(req_t w);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!(req_valid && req_ready));
  endtask

  // Limit writes only with the block idle: every request answers, so an
  // empty answer queue means nothing is in flight.
  task automatic set_limit(int value);
    req_valid <= 1'b0;
    do @(posedge clk); while (rsp_pending != 0);
    cfg_wdata <= LIMIT_W'(value);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit = value;
  endtask

  initial begin
    int phase_limits[10];
    phase_limits = '{4096, 64, 8191, 65, 1, 4095, 200, 0, 3000, 128};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // limit still zero from reset: nothing is reachable
    send_word(make_word(REQ_ALLOC, 0, '0, '0, 1'b0));
    send_word(make_word(REQ_FREE, 0, '0, '0, 1'b0));
    send_word(make_word(REQ_MARK, 0, '0, '0, 1'b1));
    send_word(make_word(REQ_MARK, 0, '0, 48'd1, 1'b1));        // starts at the limit
    send_word(make_word(REQ_MARK, 0, 48'h1000, 48'd1, 1'b1));  // starts past it
    send_word(make_word(REQ_UNKNOWN, 4095, BYTES_ALL, BYTES_ALL, 1'b1));

    set_limit(8);
    send_word(make_word(REQ_ALLOC, 0, '0, '0, 1'b0));
    send_word(make_word(REQ_ALLOC, 0, '0, '0, 1'b0));
    send_word(make_word(REQ_FREE, 1, '0, '0, 1'b0));
    send_word(make_word(REQ_FREE, 1, '0, '0, 1'b0));           // already free
    send_word(make_word(REQ_FREE, 8, '0, '0, 1'b0));           // at the limit
    send_word(make_word(REQ_FREE, 4095, '0, '0, 1'b0));
    send_word(make_word(REQ_MARK, 0, 48'hFFF, 48'd2, 1'b1));   // straddles a page edge
    send_word(make_word(REQ_MARK, 0, '0, BYTES_ALL, 1'b1));    // clamped at the limit
    send_word(make_word(REQ_ALLOC, 0, '0, '0, 1'b0));          // bitmap full
    send_word(make_word(REQ_MARK, 0, BYTES_ALL, BYTES_ALL, 1'b0));
    send_word(make_word(REQ_MARK, 0, 48'h8000, 48'h1000, 1'b0));

    // lowered limit: frames 4..7 stay used and keep counting
    set_limit(4);
    send_word(make_word(REQ_FREE, 5, '0, '0, 1'b0));
    send_word(make_word(REQ_FREE, 3, '0, '0, 1'b0));
    send_word(make_word(REQ_ALLOC, 0, '0, '0, 1'b0));
    send_word(make_word(REQ_MARK, 0, '0, 48'h10000, 1'b0));

    // limit above the frame count
    set_limit(8191);
    send_word(make_word(REQ_ALLOC, 0, '0, '0, 1'b0));
    send_word(make_word(REQ_FREE, 4095, '0, '0, 1'b0));
    send_word(make_word(REQ_MARK, 0, 48'hFFF000, 48'd1, 1'b1));
    send_word(make_word(REQ_MARK, 0, 48'h1000000, 48'd1, 1'b1));

    foreach (phase_limits[p]) begin
      set_limit(phase_limits[p]);
      repeat (PHASE_WORDS) send_word(random_word(frames_managed()));
    end

    req_valid <= 1'b0;
    do @(posedge clk); while (rsp_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0) begin
      $display("bitmap_frame_allocator_unit test passed");
    end else begin
      $display("bitmap_frame_allocator_unit test failed");
    end
    $finish;
  end

  // Result side: random ready gaps, plus one long hold-off so the output
  // register fills and the request side backs up.
  initial begin
    int gap;
    int results_taken;
    results_taken = 0;
    wait (!rst);
    forever begin
      gap = draw_gap(recv_calm);
      if (results_taken == HOLD_AT_RESULT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
      results_taken++;
    end
  end

  // watchdog: too long with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("bitmap_frame_allocator_unit test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
`default_nettype wire
